### hw/rtl/gflf_pkg.sv
// gflf_pkg: constants for the grid frontier liveness filter
// no dependencies
`timescale 1ns / 1ps
package gflf_pkg;
  localparam int unsigned MAX_W_DEF = 256;
  localparam int unsigned MAX_H_DEF = 256;
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_CSIZE  = 3'd2;
  localparam logic [2:0] REG_ORGX   = 3'd3;
  localparam logic [2:0] REG_ORGY   = 3'd4;
  localparam logic [2:0] REG_WALL   = 3'd5;
  localparam logic [2:0] REG_RADIUS = 3'd6;
  localparam logic [2:0] REG_NEED   = 3'd7;
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;
endpackage

### hw/rtl/gflf_if.sv
// gflf_if: valid/ready channel interfaces for item, result and config beats
// depends on nothing
`timescale 1ns / 1ps
interface gflf_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic [15:0] cell_index;
  logic signed [7:0] cell_value;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic last_in_batch;
  modport source(output valid, mode, cell_index, cell_value, point_x, point_y,
                 last_in_batch, input ready);
  modport sink(input valid, mode, cell_index, cell_value, point_x, point_y,
               last_in_batch, output ready);
endinterface

interface gflf_out_if;
  logic valid;
  logic ready;
  logic kept;
  logic signed [31:0] kept_x;
  logic signed [31:0] kept_y;
  logic batch_done;
  logic [15:0] kept_total;
  modport source(output valid, kept, kept_x, kept_y, batch_done, kept_total,
                 input ready);
  modport sink(input valid, kept, kept_x, kept_y, batch_done, kept_total,
               output ready);
endinterface

interface gflf_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### hw/rtl/gflf_ram.sv
// gflf_ram: generic single-port synchronous ram, registered read
// no dependencies
`timescale 1ns / 1ps
module gflf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

### hw/rtl/grid_frontier_liveness_filter.sv
// grid_frontier_liveness_filter: occupancy grid in one ram, sequential query scan
// depends on gflf_pkg, gflf_if and gflf_ram
`timescale 1ns / 1ps
// One item is taken at a time. A load writes its cell, if in range, and returns to
// idle. A query first runs one restoring divider twice (x then y) to map the point to
// a cell, then walks the clamped window row by row; each candidate cell costs a step
// state, one ram read and its wait state, plus up to eight neighbour reads with a
// wait state each, and each row end costs one more step state. A query can stop
// early once enough cells qualify. The result beat then waits for the sink.
// The single grid ram port serialises these reads. The grid needs no clearing pass.
module grid_frontier_liveness_filter
  import gflf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MAX_W_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_H_DEF
) (
  input logic clk,
  input logic rst,
  gflf_in_if.sink    in_ch,
  gflf_out_if.source out_ch,
  gflf_cfg_if.sink   cfg
);
  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW = $clog2(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_DIVX, S_DIVY, S_SETUP, S_CELL, S_CWAIT, S_NB, S_NWAIT,
    S_NEXT, S_OUT
  } state_t;

  state_t state;
  logic [8:0] gw, gh;
  logic [30:0] csize;
  logic signed [31:0] orgx, orgy;
  logic signed [7:0] wall;
  logic [3:0] radius;
  logic [9:0] need;

  logic [15:0] kcnt;
  logic signed [31:0] px, py;
  logic last;
  logic [15:0] ld_idx;
  logic signed [7:0] ld_val;

  // divider
  logic [32:0] dnum;
  logic [31:0] drem;
  logic [5:0] dcnt;
  logic dneg;
  logic signed [33:0] gx, gy;

  logic signed [13:0] x0, x1, y0, y1, cx, cy;
  logic [3:0] nb;
  logic [9:0] cnt;

  logic we;
  logic [AW-1:0] addr;
  logic [7:0] wdata, rdata;

  gflf_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  logic [12:0] w_eff, h_eff;
  always_comb begin
    w_eff = (13'(gw) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : 13'(gw);
    h_eff = (13'(gh) > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : 13'(gh);
  end

  // neighbour offset
  logic signed [1:0] ndx, ndy;
  always_comb begin
    unique case (nb)
      4'd0: begin ndx = -2'sd1; ndy = -2'sd1; end
      4'd1: begin ndx =  2'sd0; ndy = -2'sd1; end
      4'd2: begin ndx =  2'sd1; ndy = -2'sd1; end
      4'd3: begin ndx = -2'sd1; ndy =  2'sd0; end
      4'd4: begin ndx =  2'sd1; ndy =  2'sd0; end
      4'd5: begin ndx = -2'sd1; ndy =  2'sd1; end
      4'd6: begin ndx =  2'sd0; ndy =  2'sd1; end
      default: begin ndx = 2'sd1; ndy = 2'sd1; end
    endcase
  end
  logic signed [13:0] nx, ny;
  assign nx = cx + 14'(ndx);
  assign ny = cy + 14'(ndy);
  // window is clamped inside, so every neighbour is in grid
  logic [25:0] cell_lin, nb_lin;
  assign cell_lin = 26'(cy) * 26'(w_eff) + 26'(cx);
  assign nb_lin   = 26'(ny) * 26'(w_eff) + 26'(nx);

  always_comb begin
    we = 1'b0;
    addr = AW'(ld_idx);
    wdata = ld_val;
    priority case (state)
      S_LOAD: we = ({16'd0, ld_idx} < 32'(DEPTH));
      S_CELL: addr = cell_lin[AW-1:0];
      S_NB:   addr = nb_lin[AW-1:0];
      default: ;
    endcase
  end

  logic [32:0] dtrial;
  assign dtrial = {drem, dnum[32]} - {2'b0, csize};

  // signed offset of the point from the grid origin
  logic signed [32:0] offx, offy;
  assign offx = 33'(px) - 33'(orgx);
  assign offy = 33'(py) - 33'(orgy);

  logic signed [13:0] rad;
  assign rad = (radius == 4'd0) ? 14'sd1 : 14'(radius);

  function automatic logic signed [13:0] clamp(input logic signed [33:0] v,
                                               input logic signed [13:0] lo,
                                               input logic signed [13:0] hi);
    logic signed [33:0] r;
    r = v;
    if (r < 34'(lo)) r = 34'(lo);
    if (r > 34'(hi)) r = 34'(hi);
    return r[13:0];
  endfunction

  logic signed [33:0] qout;
  assign qout = dneg ? -$signed({1'b0, dnum}) : $signed({1'b0, dnum});

  assign in_ch.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kcnt <= '0;
      gw <= 9'd256; gh <= 9'd256; csize <= 31'd65536;
      orgx <= '0; orgy <= '0; wall <= 8'sd65; radius <= 4'd3; need <= 10'd1;
      out_ch.valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_WIDTH:  gw <= cfg.data[8:0];
          REG_HEIGHT: gh <= cfg.data[8:0];
          REG_CSIZE:  csize <= cfg.data[30:0];
          REG_ORGX:   orgx <= cfg.data;
          REG_ORGY:   orgy <= cfg.data;
          REG_WALL:   wall <= cfg.data[7:0];
          REG_RADIUS: radius <= cfg.data[3:0];
          default:    need <= cfg.data[9:0];
        endcase
      end
      unique case (state)
        S_IDLE: if (in_ch.valid) begin
          ld_idx <= in_ch.cell_index; ld_val <= in_ch.cell_value;
          px <= in_ch.point_x; py <= in_ch.point_y; last <= in_ch.last_in_batch;
          cnt <= '0;
          if (in_ch.mode == MODE_LOAD) state <= S_LOAD;
          else state <= S_DIVX;
          dcnt <= '0;
        end
        S_LOAD: state <= S_IDLE;
        S_DIVX, S_DIVY: begin
          if (dcnt == 6'd0) begin
            if (state == S_DIVX) begin
              dneg <= offx[32]; dnum <= offx[32] ? 33'(-offx) : 33'(offx);
            end else begin
              dneg <= offy[32]; dnum <= offy[32] ? 33'(-offy) : 33'(offy);
            end
            drem <= '0;
            dcnt <= 6'd1;
          end else if (dcnt <= 6'd33) begin
            if (!dtrial[32]) begin
              drem <= dtrial[31:0]; dnum <= {dnum[31:0], 1'b1};
            end else begin
              drem <= {drem[30:0], dnum[32]}; dnum <= {dnum[31:0], 1'b0};
            end
            dcnt <= dcnt + 6'd1;
          end else begin
            dcnt <= '0;
            if (state == S_DIVX) begin gx <= qout; state <= S_DIVY; end
            else begin gy <= qout; state <= S_SETUP; end
          end
        end
        S_SETUP: begin
          x0 <= clamp(gx - 34'(rad), 14'sd1, 14'sd8191);
          x1 <= clamp(gx + 34'(rad), -14'sd8192, 14'(w_eff) - 14'sd2);
          y0 <= clamp(gy - 34'(rad), 14'sd1, 14'sd8191);
          y1 <= clamp(gy + 34'(rad), -14'sd8192, 14'(h_eff) - 14'sd2);
          cx <= clamp(gx - 34'(rad), 14'sd1, 14'sd8191);
          cy <= clamp(gy - 34'(rad), 14'sd1, 14'sd8191);
          if (gw == 9'd0 || gh == 9'd0 || csize == 31'd0) begin
            out_ch.kept <= 1'b0; state <= S_OUT;
          end else if (need == 10'd0) begin
            out_ch.kept <= 1'b1; state <= S_OUT;
          end else state <= S_NEXT;
        end
        S_NEXT: begin
          if (cy > y1 || x0 > x1) begin
            out_ch.kept <= 1'b0; state <= S_OUT;
          end else if (cx > x1) begin
            cx <= x0; cy <= cy + 14'sd1;
          end else state <= S_CELL;
        end
        S_CELL: state <= S_CWAIT;
        S_CWAIT: begin
          nb <= '0;
          if (!rdata[7]) begin cx <= cx + 14'sd1; state <= S_NEXT; end
          else state <= S_NB;
        end
        S_NB: state <= S_NWAIT;
        S_NWAIT: begin
          if ($signed(rdata) >= wall) begin
            cx <= cx + 14'sd1; state <= S_NEXT;
          end else if (nb == 4'd7) begin
            cx <= cx + 14'sd1;
            if (cnt + 10'd1 >= need) begin out_ch.kept <= 1'b1; state <= S_OUT; end
            else begin cnt <= cnt + 10'd1; state <= S_NEXT; end
          end else begin
            nb <= nb + 4'd1; state <= S_NB;
          end
        end
        default: begin
          if (!out_ch.valid) begin
            out_ch.valid <= 1'b1;
            out_ch.kept_x <= px; out_ch.kept_y <= py;
            out_ch.batch_done <= last;
            if (last) begin
              out_ch.kept_total <= (out_ch.kept && kcnt != 16'hFFFF) ? kcnt + 16'd1 : kcnt;
              kcnt <= '0;
            end else begin
              out_ch.kept_total <= '0;
              if (out_ch.kept && kcnt != 16'hFFFF) kcnt <= kcnt + 16'd1;
            end
          end else if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

`ifndef SYNTH
  a_no_ready_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_out_only_done: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (state == S_OUT)) else $error("result outside output state");
  a_total_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.batch_done) |-> (out_ch.kept_total == 16'd0))
    else $error("total on non-last beat");
  a_write_load: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_LOAD)) else $error("grid write outside load");
`endif
endmodule
